>>> rtl/core/agbkf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// agbkf_pkg
// shared types and constants of the angle / gyro-bias kalman filter
// ----------------------------------------------------------------------------
package agbkf_pkg;

  localparam int FRAC_BITS_DEF = 24;

  localparam logic [31:0] SAMPLE_PERIOD_RST = 32'd16777;
  localparam logic [31:0] ANGLE_NOISE_RST   = 32'd16777;
  localparam logic [31:0] BIAS_NOISE_RST    = 32'd83886;
  localparam logic [31:0] MEASURE_NOISE_RST = 32'd8388608;

  localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd0;
  localparam logic [1:0] REG_ANGLE_NOISE   = 2'd1;
  localparam logic [1:0] REG_BIAS_NOISE    = 2'd2;
  localparam logic [1:0] REG_MEASURE_NOISE = 2'd3;

  // datapath operations, one per sequencer step
  typedef enum logic [4:0] {
    OP_LOAD,      // latch samples, rc = sat(rate - bias)
    OP_ANG_MUL,   // prod = rc * dt
    OP_ANG_ADD,   // ang = sat(angle + prod)
    OP_D0,        // err = sat(meas - ang), d0 = sat(qa - ab - ba), nbb = sat(-bb)
    OP_P00_MUL,   // prod = d0 * dt
    OP_P00_ADD,   // p00
    OP_NBB_MUL,   // prod = nbb * dt
    OP_P01_ADD,   // p01, p10
    OP_QDT_MUL,   // prod = qg * dt (unsigned)
    OP_P11_ADD,   // p11, den = p00 + r
    OP_DIV0_START,
    OP_DIV0_END,  // k0
    OP_DIV1_START,
    OP_DIV1_END,  // k1
    OP_C_AA_MUL,  // prod = k0 * p00
    OP_C_AA,
    OP_C_AB_MUL,
    OP_C_AB,
    OP_C_BA_MUL,
    OP_C_BA,
    OP_C_BB_MUL,
    OP_C_BB,
    OP_ANG_MUL2,  // prod = k0 * err
    OP_ANG_UPD,
    OP_BIAS_MUL,  // prod = k1 * err
    OP_BIAS_UPD,  // bias, outputs
    OP_COMMIT     // write corrected covariance
  } agbkf_op_t;

  typedef struct packed {
    logic      valid;
    agbkf_op_t op;
  } agbkf_cmd_t;

  typedef struct packed {
    logic div_busy;
  } agbkf_sts_t;

  function automatic logic [31:0] sat32(input logic signed [34:0] v);
    logic [31:0] r;
    if (v > 35'sh7FFFFFFF) r = 32'h7FFFFFFF;
    else if (v < -35'sh80000000) r = 32'h80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/agbkf_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// agbkf_div
// restoring divider, one quotient bit a cycle, signed numerator, positive den
// ----------------------------------------------------------------------------
module agbkf_div
  import agbkf_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] num,
  input  wire logic [32:0] den,
  output logic             busy,
  output logic [31:0]      quot
);
  localparam int NW = 32 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] dvd_r, dvd_nxt;
  logic [33:0]   rem_r, rem_nxt;
  logic [32:0]   den_r;
  logic          neg_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [33:0]   trial;
  logic [NW:0]   qmag;

  always_comb begin
    trial   = {rem_r[32:0], dvd_r[NW-1]} - {1'b0, den_r};
    rem_nxt = trial[33] ? {rem_r[32:0], dvd_r[NW-1]} : trial;
    dvd_nxt = {dvd_r[NW-2:0], ~trial[33]};
    cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CW'(NW);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[31];
      dvd_r <= {(num[31] ? 32'(-num) : num), {FRAC_BITS{1'b0}}};
      rem_r <= '0;
      den_r <= den;
    end else if (cnt_r != '0) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  // magnitude of num may be 2^31; quotient holds in dvd_r after the run
  always_comb begin
    qmag = {1'b0, dvd_r};
    if (neg_r) begin
      if (qmag > (NW+1)'(33'h80000000)) quot = 32'h80000000;
      else quot = 32'(-qmag[31:0]);
    end else begin
      if (qmag > (NW+1)'(32'h7FFFFFFF)) quot = 32'h7FFFFFFF;
      else quot = qmag[31:0];
    end
  end

  assign busy = (cnt_r != '0);
endmodule
`default_nettype wire

>>> rtl/core/agbkf_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// agbkf_datapath
// filter state, one shared multiplier, divider and result registers
// ----------------------------------------------------------------------------
module agbkf_datapath
  import agbkf_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire agbkf_cmd_t  cmd,
  output agbkf_sts_t       sts,
  input  wire logic [15:0] angle_sample,
  input  wire logic [15:0] rate_sample,
  input  wire logic [31:0] dt,
  input  wire logic [31:0] qa,
  input  wire logic [31:0] qg,
  input  wire logic [31:0] rn,
  output logic [31:0]      angle_est,
  output logic [31:0]      rate_est
);
  localparam logic [31:0] ONE = 32'(64'd1 << FRAC_BITS);

  logic [31:0] ang_st_r, bias_r, aa_r, ab_r, ba_r, bb_r;
  logic [31:0] meas_r, rate_r, rc_r, ang_r, err_r, d0_r, nbb_r;
  logic [31:0] p00_r, p01_r, p10_r, p11_r, k0_r, k1_r;
  logic [31:0] naa_r, nab_r, nba_r, nbb2_r;
  logic [32:0] den_r;
  logic        den_pos_r;
  logic signed [65:0] prod_r;
  logic signed [32:0] ma, mb;
  logic signed [65:0] shp;
  logic signed [34:0] pterm;
  logic        div_start, div_busy;
  logic [31:0] div_num, div_q;
  logic [33:0] den_w;

  // product reduced to the format, floor shift, clipped to 34 bits so that
  // a 35-bit sum with a 32-bit word cannot wrap before sat
  always_comb begin
    shp = prod_r >>> FRAC_BITS;
    if (shp > 66'sh1FFFFFFFF) pterm = 35'sh1FFFFFFFF;
    else if (shp < -66'sh200000000) pterm = -35'sh200000000;
    else pterm = shp[34:0];
  end

  function automatic logic signed [34:0] sx(input logic [31:0] v);
    return {{3{v[31]}}, v};
  endfunction

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.op)
      OP_ANG_MUL:  begin ma = {rc_r[31], rc_r};   mb = {1'b0, dt}; end
      OP_P00_MUL:  begin ma = {d0_r[31], d0_r};   mb = {1'b0, dt}; end
      OP_NBB_MUL:  begin ma = {nbb_r[31], nbb_r}; mb = {1'b0, dt}; end
      OP_QDT_MUL:  begin ma = {1'b0, qg};         mb = {1'b0, dt}; end
      OP_C_AA_MUL: begin ma = {k0_r[31], k0_r};   mb = {p00_r[31], p00_r}; end
      OP_C_AB_MUL: begin ma = {k0_r[31], k0_r};   mb = {p01_r[31], p01_r}; end
      OP_C_BA_MUL: begin ma = {k1_r[31], k1_r};   mb = {p00_r[31], p00_r}; end
      OP_C_BB_MUL: begin ma = {k1_r[31], k1_r};   mb = {p01_r[31], p01_r}; end
      OP_ANG_MUL2: begin ma = {k0_r[31], k0_r};   mb = {err_r[31], err_r}; end
      OP_BIAS_MUL: begin ma = {k1_r[31], k1_r};   mb = {err_r[31], err_r}; end
      default:     begin ma = '0; mb = '0; end
    endcase
  end

  assign den_w     = {{2{p00_r[31]}}, p00_r} + {2'b00, rn};
  assign div_start = cmd.valid && (cmd.op == OP_DIV0_START || cmd.op == OP_DIV1_START);
  assign div_num   = (cmd.op == OP_DIV1_START) ? p10_r : p00_r;

  agbkf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (den_r),
    .busy  (div_busy),
    .quot  (div_q)
  );

  assign sts.div_busy = div_busy;

  always_ff @(posedge clk) begin
    prod_r <= 66'(ma * mb);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_st_r <= '0;
      bias_r   <= '0;
      aa_r     <= ONE;
      ab_r     <= '0;
      ba_r     <= '0;
      bb_r     <= ONE;
    end else if (cmd.valid) begin
      case (cmd.op)
        OP_ANG_UPD:  ang_st_r <= sat32(sx(ang_r) + pterm);
        OP_BIAS_UPD: bias_r <= sat32(sx(bias_r) + pterm);
        OP_COMMIT: begin
          aa_r <= naa_r;
          ab_r <= nab_r;
          ba_r <= nba_r;
          bb_r <= nbb2_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid) begin
      case (cmd.op)
        OP_LOAD: begin
          meas_r <= {angle_sample, 16'h0};
          rate_r <= {rate_sample, 16'h0};
          rc_r   <= sat32({{3{rate_sample[15]}}, rate_sample, 16'h0} - sx(bias_r));
        end
        OP_ANG_ADD: begin
          ang_r <= sat32(sx(ang_st_r) + pterm);
        end
        OP_D0: begin
          err_r <= sat32(sx(meas_r) - sx(ang_r));
          d0_r  <= sat32({3'b000, qa} - sx(ab_r) - sx(ba_r));
          nbb_r <= sat32(-sx(bb_r));
        end
        OP_P00_ADD: p00_r <= sat32(sx(aa_r) + pterm);
        OP_P01_ADD: begin
          p01_r <= sat32(sx(ab_r) + pterm);
          p10_r <= sat32(sx(ba_r) + pterm);
        end
        OP_P11_ADD: begin
          p11_r     <= sat32(sx(bb_r) + pterm);
          den_r     <= den_w[32:0];
          den_pos_r <= !den_w[33] && (den_w != '0);
        end
        OP_DIV0_END: k0_r <= den_pos_r ? div_q : '0;
        OP_DIV1_END: k1_r <= den_pos_r ? div_q : '0;
        OP_C_AA: naa_r  <= sat32(sx(p00_r) - pterm);
        OP_C_AB: nab_r  <= sat32(sx(p01_r) - pterm);
        OP_C_BA: nba_r  <= sat32(sx(p10_r) - pterm);
        OP_C_BB: nbb2_r <= sat32(sx(p11_r) - pterm);
        OP_BIAS_UPD: begin
          angle_est <= ang_st_r;
          rate_est  <= sat32(sx(rate_r) - sx(sat32(sx(bias_r) + pterm)));
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/agbkf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// agbkf_ctrl
// sequencer: steps the datapath through one filter update per request
// ----------------------------------------------------------------------------
module agbkf_ctrl
  import agbkf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_fire,
  input  wire logic out_fire,
  input  wire agbkf_sts_t sts,
  output agbkf_cmd_t cmd,
  output logic busy,
  output logic out_valid
);
  typedef enum logic [1:0] {S_IDLE, S_RUN, S_WAIT} state_t;

  state_t    state_r;
  agbkf_op_t op_r;
  logic      ovalid_r;

  always_comb begin
    cmd.valid = 1'b0;
    cmd.op    = op_r;
    if (in_fire) begin
      cmd.valid = 1'b1;
      cmd.op    = OP_LOAD;
    end else if (state_r == S_RUN) begin
      cmd.valid = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      op_r     <= OP_LOAD;
      ovalid_r <= 1'b0;
    end else begin
      if (out_fire) ovalid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            state_r <= S_RUN;
            op_r    <= OP_ANG_MUL;
          end
        end
        S_RUN: begin
          unique case (op_r)
            OP_DIV0_START, OP_DIV1_START: begin
              state_r <= S_WAIT;
              op_r    <= agbkf_op_t'(op_r + 5'd1);
            end
            OP_COMMIT: state_r <= S_IDLE;
            OP_BIAS_UPD: begin
              ovalid_r <= 1'b1;
              op_r     <= OP_COMMIT;
            end
            default: op_r <= agbkf_op_t'(op_r + 5'd1);
          endcase
        end
        S_WAIT: begin
          if (!sts.div_busy) state_r <= S_RUN;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // a new request waits until the previous result has been taken
  assign busy      = (state_r != S_IDLE) || ovalid_r;
  assign out_valid = ovalid_r;
endmodule
`default_nettype wire

>>> rtl/core/angle_gyro_bias_kalman_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// angle_gyro_bias_kalman_filter
// two-state angle / gyro-bias kalman filter with apb settings
// ----------------------------------------------------------------------------
// usage:
//  in_* stream: one request carries a measured angle and rate (sensor units).
//  out_* stream: one result per request, filtered angle and corrected rate,
//  both signed Q16.16, saturated.
//  cfg_* apb port: dt, angle noise, bias noise, measurement noise at byte
//  addresses 0, 4, 8, 12; write only while no request is in flight.
//  each result comes from the shared multiplier steps and two runs of the
//  bit-serial divider.
//  one request at a time: in_tready is low from acceptance until the result
//  has been taken, so a stalled receiver holds off the next request.
//  reset: filter state back to zero angle and bias, unit covariance, and
//  settings to their defaults.
// ----------------------------------------------------------------------------
module angle_gyro_bias_kalman_filter
  import agbkf_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // angle_sample[15:0], rate_sample[31:16]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // angle_estimate[31:0], rate_estimate[63:32]
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  logic [31:0] dt_r, qa_r, qg_r, rn_r;
  logic        busy, in_fire, out_fire;
  agbkf_cmd_t  cmd;
  agbkf_sts_t  sts;
  logic [31:0] ang_est, rate_est;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r <= SAMPLE_PERIOD_RST;
      qa_r <= ANGLE_NOISE_RST;
      qg_r <= BIAS_NOISE_RST;
      rn_r <= MEASURE_NOISE_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_paddr[3:2])
        REG_SAMPLE_PERIOD: dt_r <= cfg_pwdata;
        REG_ANGLE_NOISE:   qa_r <= cfg_pwdata;
        REG_BIAS_NOISE:    qg_r <= cfg_pwdata;
        REG_MEASURE_NOISE: rn_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_SAMPLE_PERIOD: cfg_prdata = dt_r;
      REG_ANGLE_NOISE:   cfg_prdata = qa_r;
      REG_BIAS_NOISE:    cfg_prdata = qg_r;
      REG_MEASURE_NOISE: cfg_prdata = rn_r;
      default:           cfg_prdata = '0;
    endcase
  end

  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;
  assign out_tdata = {rate_est, ang_est};

  agbkf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .out_fire  (out_fire),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_tvalid)
  );

  agbkf_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .angle_sample (in_tdata[15:0]),
    .rate_sample  (in_tdata[31:16]),
    .dt           (dt_r),
    .qa           (qa_r),
    .qg           (qg_r),
    .rn           (rn_r),
    .angle_est    (ang_est),
    .rate_est     (rate_est)
  );
endmodule
`default_nettype wire

>>> verif/agbkf_checker.sv
// ----------------------------------------------------------------------------
// agbkf_checker
// watches the sample, result and settings ports of the kalman filter, keeps
// its own copy of the filter state, predicts each result and compares it
// ----------------------------------------------------------------------------
module agbkf_checker
  import agbkf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [31:0] in_tdata,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [63:0] out_tdata,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  input  wire logic        cfg_pready,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = FRAC_BITS_DEF;

  typedef struct {
    logic signed [31:0] angle;
    logic signed [31:0] rate;
  } estimate_t;

  estimate_t estimate_q[$];

  logic [31:0] dt_r, qa_r, qg_r, rn_r;
  logic signed [31:0] ang_s, bias_s, p_aa, p_ab, p_ba, p_bb;

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFFFFFF;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // signed by unsigned q product, floor shift
  function automatic longint mul_su(logic signed [31:0] a, logic [31:0] b);
    longint p;
    p = longint'(a) * longint'({32'd0, b});
    return p >>> FB;
  endfunction

  function automatic longint mul_ss(logic signed [31:0] a, logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return p >>> FB;
  endfunction

  function automatic logic signed [31:0] kgain(logic signed [31:0] num, longint den);
    longint n;
    if (den <= 0) return 32'sd0;
    n = longint'(num) * (64'sd1 <<< FB);
    return clamp32(n / den);
  endfunction

  task automatic filter_step(logic [31:0] sample);
    longint meas, rate, qdt, den;
    logic signed [31:0] rc, ang, err, d0, nbb, p00, p01, p10, p11, k0, k1;
    estimate_t e;
    meas = longint'($signed(sample[15:0])) * 65536;
    rate = longint'($signed(sample[31:16])) * 65536;
    rc  = clamp32(rate - longint'(bias_s));
    ang = clamp32(longint'(ang_s) + mul_su(rc, dt_r));
    err = clamp32(meas - longint'(ang));
    d0  = clamp32(longint'({32'd0, qa_r}) - longint'(p_ab) - longint'(p_ba));
    nbb = clamp32(-longint'(p_bb));
    p00 = clamp32(longint'(p_aa) + mul_su(d0, dt_r));
    p01 = clamp32(longint'(p_ab) + mul_su(nbb, dt_r));
    p10 = clamp32(longint'(p_ba) + mul_su(nbb, dt_r));
    qdt = longint'(({32'd0, qg_r} * {32'd0, dt_r}) >> FB);
    p11 = clamp32(longint'(p_bb) + qdt);
    den = longint'(p00) + longint'({32'd0, rn_r});
    k0  = kgain(p00, den);
    k1  = kgain(p10, den);
    p_aa = clamp32(longint'(p00) - mul_ss(k0, p00));
    p_ab = clamp32(longint'(p01) - mul_ss(k0, p01));
    p_ba = clamp32(longint'(p10) - mul_ss(k1, p00));
    p_bb = clamp32(longint'(p11) - mul_ss(k1, p01));
    ang_s  = clamp32(longint'(ang) + mul_ss(k0, err));
    bias_s = clamp32(longint'(bias_s) + mul_ss(k1, err));
    e.angle = ang_s;
    e.rate  = clamp32(rate - longint'(bias_s));
    estimate_q.push_back(e);
  endtask

  always @(posedge clk) begin
    estimate_t e;
    int errs;
    errs = 0;
    if (!rst_n) begin
      dt_r <= SAMPLE_PERIOD_RST;
      qa_r <= ANGLE_NOISE_RST;
      qg_r <= BIAS_NOISE_RST;
      rn_r <= MEASURE_NOISE_RST;
      ang_s = 0; bias_s = 0; p_ab = 0; p_ba = 0;
      p_aa = 32'sd1 <<< FB;
      p_bb = 32'sd1 <<< FB;
      estimate_q.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          REG_SAMPLE_PERIOD: dt_r <= cfg_pwdata;
          REG_ANGLE_NOISE:   qa_r <= cfg_pwdata;
          REG_BIAS_NOISE:    qg_r <= cfg_pwdata;
          REG_MEASURE_NOISE: rn_r <= cfg_pwdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) filter_step(in_tdata);
      if (out_tvalid && out_tready) begin
        if (estimate_q.size() == 0) begin
          $error("result with no request outstanding: %h", out_tdata);
          errs = errs + 1;
        end else begin
          e = estimate_q.pop_front();
          if (out_tdata[31:0] !== e.angle) begin
            $error("angle_estimate expected %h actual %h", e.angle, out_tdata[31:0]);
            errs = errs + 1;
          end
          if (out_tdata[63:32] !== e.rate) begin
            $error("rate_estimate expected %h actual %h", e.rate, out_tdata[63:32]);
            errs = errs + 1;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending <= estimate_q.size();
    end
  end

endmodule

>>> verif/tb_angle_gyro_bias_kalman_filter.sv
// ----------------------------------------------------------------------------
// tb_angle_gyro_bias_kalman_filter
// drives sample requests and settings through several noise and timing
// phases, with random idling on both streams; the checker scores results
// ----------------------------------------------------------------------------
module tb_angle_gyro_bias_kalman_filter
  import agbkf_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;     // angle_sample[15:0], rate_sample[31:16]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;         // angle_estimate[31:0], rate_estimate[63:32]
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int fail_count;
  int pending;
  int tx_gap_pct = 0;
  int rx_stall_pct = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  angle_gyro_bias_kalman_filter i_dut (.*);

  agbkf_checker i_checker (.*);

  always @(posedge clk) out_tready <= ($urandom_range(99) >= rx_stall_pct);

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (160) @(posedge clk);
  endtask

  task automatic apply_cfg(logic [31:0] dt, logic [31:0] qa, logic [31:0] qg,
                           logic [31:0] rn);
    drain();
    write_reg(REG_SAMPLE_PERIOD, dt);
    write_reg(REG_ANGLE_NOISE, qa);
    write_reg(REG_BIAS_NOISE, qg);
    write_reg(REG_MEASURE_NOISE, rn);
  endtask

  task automatic send(logic [15:0] angle, logic [15:0] rate);
    logic rdy;
    in_tvalid <= 1'b1;
    in_tdata <= {rate, angle};
    do begin
      @(negedge clk);
      rdy = in_tready;
      @(posedge clk);
    end while (!rdy);
    if ($urandom_range(99) < tx_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // mostly slowly moving sensor traces, with some full-range noise
  task automatic random_run(int n, bit hold_mid);
    int a, r;
    a = $signed(16'($urandom));
    r = $signed(16'($urandom_range(0, 400))) - 200;
    for (int i = 0; i < n; i++) begin
      if (hold_mid && i == n / 2) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      if ($urandom_range(99) < 20) begin
        send(16'($urandom), 16'($urandom));
      end else begin
        a = a + $signed($urandom_range(0, 64)) - 32;
        r = r + $signed($urandom_range(0, 16)) - 8;
        if (a > 32767) a = 32767;
        if (a < -32768) a = -32768;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        send(16'(a), 16'(r));
      end
    end
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    apply_cfg(SAMPLE_PERIOD_RST, ANGLE_NOISE_RST, BIAS_NOISE_RST, MEASURE_NOISE_RST);
    send(16'h0000, 16'h0000);
    send(16'h7FFF, 16'h7FFF);
    send(16'h8000, 16'h8000);
    send(16'h7FFF, 16'h8000);
    send(16'h8000, 16'h7FFF);
    send(16'h0001, 16'hFFFF);
    send(16'hFFFF, 16'h0001);
    send(16'h5555, 16'hAAAA);
    send(16'hAAAA, 16'h5555);
    send(16'h0000, 16'h0000);
    in_tvalid <= 1'b0;
    @(posedge clk);
    random_run(60, 1'b0);

    // zero period and zero measurement noise, gains may vanish
    tx_gap_pct = 51;
    apply_cfg(32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0);
    send(16'h7FFF, 16'h8000);
    send(16'h8000, 16'h7FFF);
    random_run(60, 1'b0);

    // largest period, bias noise and measurement noise, with zero angle noise, drive saturation everywhere
    tx_gap_pct = 0; rx_stall_pct = 51;
    apply_cfg(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(16'h7FFF, 16'h7FFF);
    send(16'h8000, 16'h8000);
    random_run(60, 1'b0);

    tx_gap_pct = 22; rx_stall_pct = 22;
    apply_cfg($urandom, $urandom, $urandom, $urandom);
    random_run(70, 1'b0);

    tx_gap_pct = 0; rx_stall_pct = 0;
    apply_cfg(32'd1677721, 32'd16777, 32'd83886, 32'd16777);
    random_run(70, 1'b1);

    tx_gap_pct = 51;
    apply_cfg($urandom_range(0, 32'h00FF_FFFF), $urandom, $urandom_range(0, 32'h0FFF_FFFF),
              $urandom);
    random_run(70, 1'b0);

    tx_gap_pct = 0; rx_stall_pct = 51;
    apply_cfg(32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
    random_run(40, 1'b0);
    apply_cfg($urandom, $urandom, $urandom, $urandom_range(0, 32'd100));
    random_run(60, 1'b0);

    tx_gap_pct = 22; rx_stall_pct = 22;
    apply_cfg(SAMPLE_PERIOD_RST, ANGLE_NOISE_RST, BIAS_NOISE_RST, MEASURE_NOISE_RST);
    random_run(70, 1'b0);

    drain();
    if (fail_count == 0) begin
      $display("angle_gyro_bias_kalman_filter regression: pass");
    end else begin
      $display("angle_gyro_bias_kalman_filter regression: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("angle_gyro_bias_kalman_filter regression: fail");
    $finish;
  end

endmodule
